@@ sv/aes128_block_encrypt_top_assert.svh @@
// Assertion macros for the AES-128 encryption block checker
`ifndef AES128_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_TOP_ASSERT_SVH
// implication checked every clock, off during reset
`define AES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aes assertion failed");
// next-cycle implication
`define AES_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aes assertion failed");
`endif

@@ sv/aes_pkg.sv @@
// Package: AES types, S-box and GF(2^8) helpers
package aes_pkg;
  localparam int NumRounds = 10;
  localparam logic [7:0] RedPoly = 8'h1b;
  localparam logic [0:0] CfgKeyHi = 1'b0;
  localparam logic [0:0] CfgKeyLo = 1'b1;

  typedef logic [127:0] blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? RedPoly : 8'h00);
  endfunction

  // byte k sits in bits 127-8k down
  function automatic logic [7:0] get_byte(input blk_t b, input int k);
    get_byte = b[127-8*k -: 8];
  endfunction
endpackage

@@ sv/aes_key_cell.sv @@
// Key schedule cell: derives the next round key from the one it is handed
module aes_key_cell import aes_pkg::*; (
  input  logic [127:0] key_in,
  input  logic [7:0]   rcon,
  output logic [127:0] key_out
);
  logic [31:0] w0, w1, w2, w3, t;
  always_comb begin
    w0 = key_in[127:96];
    w1 = key_in[95:64];
    w2 = key_in[63:32];
    w3 = key_in[31:0];
    // RotWord then SubWord on the last column
    t = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    key_out[127:96] = w0 ^ t;
    key_out[95:64]  = w1 ^ w0 ^ t;
    key_out[63:32]  = w2 ^ w1 ^ w0 ^ t;
    key_out[31:0]   = w3 ^ w2 ^ w1 ^ w0 ^ t;
  end
endmodule

@@ sv/aes_round_cell.sv @@
// Round cell: one AES round with its key step, registered
module aes_round_cell import aes_pkg::*; #(
  parameter bit LastRound = 1'b0
) (
  input  logic         clk,
  input  logic         en,
  input  logic [127:0] state_in,
  input  logic [127:0] key_in,
  input  logic [7:0]   rcon,
  output logic [127:0] state_out,
  output logic [127:0] key_out
);
  logic [127:0] rk, ss, mx, state_r, key_r;

  aes_key_cell u_key (.key_in(key_in), .rcon(rcon), .key_out(rk));

  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[127-8*(c*4+r) -: 8] = SBOX[get_byte(state_in, ((c + r) % 4) * 4 + r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(ss, c*4);
      a1 = get_byte(ss, c*4+1);
      a2 = get_byte(ss, c*4+2);
      a3 = get_byte(ss, c*4+3);
      mx[127-8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      mx[127-8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      mx[127-8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      mx[127-8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= (LastRound ? ss : mx) ^ rk;
      key_r   <= rk;
    end
  end

  assign state_out = state_r;
  assign key_out   = key_r;
endmodule

@@ sv/aes128_block_encrypt_top.sv @@
// Top level: AES-128 encryption as a ten-cell round pipeline
// Usage:
//   Input words (in_plain_hi/lo) are accepted when in_valid is high and
//   in_stall is low. Ciphertext words leave on out_cipher_hi/lo with
//   out_valid, taken when out_stall is low.
//   Key is written through cfg_we/cfg_index/cfg_data (0 = key_hi,
//   1 = key_lo); the user writes it only while the pipeline is empty,
//   which the block itself does not enforce.
// Path from accept to out_valid: the initial key add register, then
//   one cell per round. Throughput: one word per cycle unless stalled;
//   every cell carries its block and round key on to the next cell.
// Stall: the whole chain holds when the output word is not taken, so
//   in_stall follows out_stall while the last stage is full.
// Reset: clears the key registers and all stage valid bits.
module aes128_block_encrypt_top import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_plain_hi,
  input  logic [63:0] in_plain_lo,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_cipher_hi,
  output logic [63:0] out_cipher_lo,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  logic [63:0] key_hi_r, key_lo_r;
  logic [NumRounds:0] vld_r;
  logic adv;
  logic [127:0] st [NumRounds+1];
  logic [127:0] ky [NumRounds+1];
  logic [127:0] st0_r, ky0_r;
  localparam logic [7:0] RCON [NumRounds] = '{8'h01,8'h02,8'h04,8'h08,8'h10,
                                             8'h20,8'h40,8'h80,8'h1b,8'h36};

  assign adv = !(vld_r[NumRounds] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      vld_r    <= '0;
    end else begin
      if (cfg_we && cfg_index == CfgKeyHi) key_hi_r <= cfg_data;
      if (cfg_we && cfg_index == CfgKeyLo) key_lo_r <= cfg_data;
      if (adv) vld_r <= {vld_r[NumRounds-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st0_r <= {in_plain_hi, in_plain_lo} ^ {key_hi_r, key_lo_r};
      ky0_r <= {key_hi_r, key_lo_r};
    end
  end

  assign st[0] = st0_r;
  assign ky[0] = ky0_r;

  for (genvar i = 0; i < NumRounds; i++) begin : g_cell
    aes_round_cell #(.LastRound(i == NumRounds-1)) u_cell (
      .clk(clk), .en(adv), .state_in(st[i]), .key_in(ky[i]), .rcon(RCON[i]),
      .state_out(st[i+1]), .key_out(ky[i+1]));
  end

  assign out_valid     = vld_r[NumRounds];
  assign out_cipher_hi = st[NumRounds][127:64];
  assign out_cipher_lo = st[NumRounds][63:0];
endmodule

@@ sv/aes128_block_encrypt_chk.sv @@
// Port checker for the AES-128 encryption block, with its bind
`include "aes128_block_encrypt_top_assert.svh"
module aes128_block_encrypt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_cipher_hi,
  input logic [63:0] out_cipher_lo
);
  `AES_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_cipher_hi) && $stable(out_cipher_lo))
  `AES_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)
  `AES_ASSERT_IMP(a_no_stall, !out_valid, !in_stall)
endmodule

bind aes128_block_encrypt_top aes128_block_encrypt_chk u_chk (.*);
